### src/upc_pkg.sv
// Package for the URL percent codec: register indexes, mode and phase codes,
// the result bundle and the character class functions.
// No dependencies.
package upc_pkg;

	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 3;

	typedef logic [CfgIdxW-1:0]  cfg_idx_t;
	typedef logic [CfgDataW-1:0] cfg_data_t;
	typedef logic [2:0]          mode_t;

	localparam cfg_idx_t REG_DIRECTION = 1'd0;
	localparam cfg_idx_t REG_ESC_MODE  = 1'd1;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam mode_t MODE_PATH     = 3'd0;
	localparam mode_t MODE_SEGMENT  = 3'd1;
	localparam mode_t MODE_HOST     = 3'd2;
	localparam mode_t MODE_ZONE     = 3'd3;
	localparam mode_t MODE_USERINFO = 3'd4;
	localparam mode_t MODE_QUERY    = 3'd5;
	localparam mode_t MODE_FRAGMENT = 3'd6;
	localparam mode_t MODE_SPARE    = 3'd7;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PCT  = 3'b010,
		PH_HIGH = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            last;
		logic            error;
	} res_t;

	function automatic logic needs_escape(input logic [7:0] c, input mode_t mode);
		logic r;
		logic host_like;
		r = 1'b1;
		host_like = (mode == MODE_HOST) || (mode == MODE_ZONE);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
			r = 1'b0;
		end else if (host_like && (c == "!" || c == "$" || c == "&" || c == "'" || c == "("
				|| c == ")" || c == "*" || c == "+" || c == "," || c == ";" || c == "="
				|| c == ":" || c == "[" || c == "]" || c == "<" || c == ">"
				|| c == 8'h22)) begin
			r = 1'b0;
		end else if (c == "-" || c == "_" || c == "." || c == "~") begin
			r = 1'b0;
		end else if ((c == "$" || c == "&" || c == "+" || c == "," || c == "/" || c == ":"
				|| c == ";" || c == "=" || c == "?" || c == "@")
				&& !host_like && mode != MODE_SPARE) begin
			case (mode)
				MODE_PATH:     r = (c == "?");
				MODE_SEGMENT:  r = (c == "/" || c == ";" || c == "," || c == "?");
				MODE_USERINFO: r = (c == "@" || c == "/" || c == "?" || c == ":");
				MODE_QUERY:    r = 1'b1;
				default:       r = 1'b0;
			endcase
		end else if (mode == MODE_FRAGMENT && (c == "!" || c == "(" || c == ")" || c == "*")) begin
			r = 1'b0;
		end
		return r;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9")
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= "a" && c <= "f")
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= "A" && c <= "F")
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10)
			r = 8'h30 + {4'd0, n};
		else
			r = 8'h37 + {4'd0, n};
		return r;
	endfunction

endpackage

### src/upc_if.sv
// Stream interfaces of the URL percent codec: input byte channel and result
// channel, each with valid/ready handshake.
// No dependencies.
interface upc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_error;

	modport source (output valid, output out_byte, output out_last, output out_error, input ready);
	modport sink   (input valid, input out_byte, input out_last, input out_error, output ready);
endinterface

### src/upc_core.sv
// Input register and codec logic: escape state and result bundle per byte.
// Depends on upc_pkg and upc_if.
module upc_core (
	input  logic             clk,
	input  logic             arst_n,
	upc_in_if.sink           ingress,
	input  logic             dir,
	input  upc_pkg::mode_t   mode,
	output upc_pkg::res_t    res,
	output logic             res_valid,
	input  logic             res_ready
);
	import upc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	phase_t     phase_q;
	logic [3:0] hnib_q;
	logic       err_q;

	phase_t     phase_n;
	logic [3:0] hnib_n;
	logic       err_n;
	logic       new_err;
	logic       err_out;
	logic       esc;
	logic [4:0] hv;
	logic [7:0] dec_val;
	logic       advance;

	assign esc     = needs_escape(byte_s1, mode);
	assign hv      = hex_value(byte_s1);
	assign dec_val = {hnib_q, hv[3:0]};

	always_comb begin
		res       = '0;
		phase_n   = phase_q;
		hnib_n    = hnib_q;
		new_err   = 1'b0;
		if (!err_q) begin
			if (dir == DIR_ENCODE) begin
				if (esc && byte_s1 == CH_SPACE && mode == MODE_QUERY) begin
					res.cnt      = 2'd1;
					res.bytes[0] = CH_PLUS;
				end else if (esc) begin
					res.cnt      = 2'd3;
					res.bytes[0] = CH_PCT;
					res.bytes[1] = hex_char(byte_s1[7:4]);
					res.bytes[2] = hex_char(byte_s1[3:0]);
				end else begin
					res.cnt      = 2'd1;
					res.bytes[0] = byte_s1;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (byte_s1 == CH_PCT) begin
							phase_n = PH_PCT;
						end else if (byte_s1 == CH_PLUS) begin
							res.cnt      = 2'd1;
							res.bytes[0] = (mode == MODE_QUERY) ? CH_SPACE : CH_PLUS;
						end else if ((mode == MODE_HOST || mode == MODE_ZONE)
								&& !byte_s1[7] && esc) begin
							new_err = 1'b1;
						end else begin
							res.cnt      = 2'd1;
							res.bytes[0] = byte_s1;
						end
					end
					PH_PCT: begin
						if (!hv[4]) begin
							new_err = 1'b1;
						end else begin
							hnib_n  = hv[3:0];
							phase_n = PH_HIGH;
						end
					end
					PH_HIGH: begin
						if (!hv[4]) begin
							new_err = 1'b1;
						end else begin
							if (mode == MODE_HOST && !hnib_q[3] && dec_val != CH_PCT) begin
								new_err = 1'b1;
							end else if (mode == MODE_ZONE && dec_val != CH_PCT
									&& dec_val != CH_SPACE && needs_escape(dec_val, MODE_HOST)) begin
								new_err = 1'b1;
							end else begin
								res.cnt      = 2'd1;
								res.bytes[0] = dec_val;
							end
							phase_n = PH_IDLE;
							hnib_n  = 4'd0;
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end
		err_out = err_q | new_err;
		if (new_err)
			res.cnt = 2'd0;
		err_n = err_out;
		if (last_s1) begin
			if (dir == DIR_DECODE && phase_n != PH_IDLE)
				err_out = 1'b1;
			if (err_out) begin
				res       = '0;
				res.cnt   = 2'd1;
				res.error = 1'b1;
			end else if (res.cnt == 2'd0) begin
				res.cnt = 2'd1;
			end
			res.last = 1'b1;
			phase_n  = PH_IDLE;
			hnib_n   = 4'd0;
			err_n    = 1'b0;
		end
	end

	assign advance       = valid_s1 && (res.cnt == 2'd0 || res_ready);
	assign res_valid     = valid_s1 && res.cnt != 2'd0;
	assign ingress.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			hnib_q   <= 4'd0;
			err_q    <= 1'b0;
		end else begin
			if (ingress.ready)
				valid_s1 <= ingress.valid;
			if (advance) begin
				phase_q <= phase_n;
				hnib_q  <= hnib_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.ready && ingress.valid) begin
			byte_s1 <= ingress.in_byte;
			last_s1 <= ingress.in_last;
		end
	end

endmodule

### src/upc_serializer.sv
// Result register: holds up to three result bytes and hands them out one per
// transaction. Depends on upc_pkg and upc_if.
module upc_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  upc_pkg::res_t   res,
	input  logic            res_valid,
	output logic            res_ready,
	upc_out_if.source       egress
);
	import upc_pkg::*;

	logic [1:0]      cnt_q;
	logic [2:0][7:0] bytes_q;
	logic            last_q;
	logic            err_q;
	logic            pop;
	logic            load;

	assign pop       = egress.valid && egress.ready;
	assign res_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && egress.ready);
	assign load      = res_valid && res_ready;

	assign egress.valid     = cnt_q != 2'd0;
	assign egress.out_byte  = bytes_q[0];
	assign egress.out_last  = last_q && cnt_q == 2'd1;
	assign egress.out_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			last_q  <= res.last;
			err_q   <= res.error;
		end else if (pop) begin
			bytes_q <= {8'd0, bytes_q[2:1]};
		end
	end

endmodule

### src/url_percent_codec.sv
// URL percent codec top level: configuration registers, codec core and
// result serializer. Depends on upc_pkg, upc_if, upc_core and upc_serializer.
//
// Percent-encodes or decodes the bytes of one URL component, one input
// transaction per byte, with in_last on the final byte. The input side takes
// a byte every cycle while the result side keeps up; a byte passes through an
// input register and then the result register, from which its first result
// is offered. A byte that encodes to %XX yields three results, drained one
// per cycle by the result register while the output is ready, and the input
// stalls behind it. Decoding yields at most one result per byte and none for
// escape digits still pending. Once an error is found in a string no data
// results follow; the last byte then yields one result with out_error and
// out_last set and out_byte zero. A string that yields no data still gives
// one empty result with out_last. Write direction and escape_mode only while
// the block is idle.
module url_percent_codec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  upc_pkg::cfg_idx_t   cfg_index,
	input  upc_pkg::cfg_data_t  cfg_data,
	upc_in_if.sink              ingress,
	upc_out_if.source           egress
);
	import upc_pkg::*;

	logic  dir_q;
	mode_t mode_q;
	res_t  res;
	logic  res_valid;
	logic  res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_ENCODE;
			mode_q <= MODE_PATH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECTION: dir_q  <= cfg_data[0];
				REG_ESC_MODE:  mode_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	upc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ingress   (ingress),
		.dir       (dir_q),
		.mode      (mode_q),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	upc_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.egress    (egress)
	);

endmodule

### src/upc_checker.sv
// Port-level checks for the URL percent codec, bound to the top level.
// Depends on url_percent_codec.
module upc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       out_error
);

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_last)
		else $error("error result without last mark");

	a_error_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_byte == 8'd0)
		else $error("error result carries a non-zero byte");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transaction");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last) && $stable(out_error))
		else $error("result payload changed while stalled");

endmodule

bind url_percent_codec upc_checker u_upc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (egress.valid),
	.out_ready (egress.ready),
	.out_byte  (egress.out_byte),
	.out_last  (egress.out_last),
	.out_error (egress.out_error)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for url_percent_codec: directed and random byte strings
// in both directions and every escape mode, checked against a behavioural codec.
// Depends on upc_pkg, upc_if and the url_percent_codec RTL.
module tb_top;
	import upc_pkg::*;

	localparam int    CYCLE_LIMIT = 200000;
	localparam int    DRAIN       = 8;
	localparam int    IDLE_PCT    = 22;
	localparam int    RAND_ITEMS  = 240;
	localparam int    HOLD_AT     = 120;
	localparam int    HOLD_CYCLES = 60;
	localparam int    HOLD_MIN_PENDING = 6;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_OPEN = 2'd1;
	localparam logic [1:0] ESC_HALF = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} in_item_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	cfg_idx_t  cfg_index = '0;
	cfg_data_t cfg_data  = '0;

	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_taken  = 1'b0;

	upc_in_if  ingress_bus ();
	upc_out_if egress_bus ();

	assign ingress_bus.valid   = in_valid;
	assign ingress_bus.in_byte = in_byte;
	assign ingress_bus.in_last = in_last;
	assign egress_bus.ready    = out_ready;

	url_percent_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ingress   (ingress_bus),
		.egress    (egress_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic       cur_dir  = DIR_ENCODE;
	mode_t      cur_mode = MODE_PATH;
	logic [1:0] esc_phase = ESC_NONE;
	logic [3:0] hi_nib    = 4'd0;
	logic       err_seen  = 1'b0;

	in_item_t pending_bytes [$];
	result_t  expected_chars [$];

	int items_queued   = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int fail_count     = 0;
	int cycle_count    = 0;
	int in_idle_pct    = IDLE_PCT;
	int out_idle_pct   = IDLE_PCT;
	int hold_left      = 0;
	logic hold_done    = 1'b0;

	function automatic logic in_str(input logic [7:0] c, input string s);
		for (int i = 0; i < s.len(); i++)
			if (s[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic esc_required(input logic [7:0] c, input mode_t m);
		logic hostish;
		hostish = (m == MODE_HOST) || (m == MODE_ZONE);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
			return 1'b0;
		if (hostish && in_str(c, "!$&'()*+,;=:[]<>\""))
			return 1'b0;
		if (in_str(c, "-_.~"))
			return 1'b0;
		if (in_str(c, "$&+,/:;=?@")) begin
			case (m)
				MODE_PATH:     return c == "?";
				MODE_SEGMENT:  return in_str(c, "/;,?");
				MODE_USERINFO: return in_str(c, "@/?:");
				MODE_QUERY:    return 1'b1;
				MODE_FRAGMENT: return 1'b0;
				default: ;
			endcase
		end
		if (m == MODE_FRAGMENT && in_str(c, "!()*"))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [4:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, c[3:0]};
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + 8'(n);
		return "A" + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] rand_hex_char(input logic [3:0] n);
		logic [7:0] ch;
		ch = nibble_char(n);
		if (n > 4'd9 && $urandom_range(1) == 1)
			ch = ch | 8'h20;
		return ch;
	endfunction

	task automatic percent_codec_step(input logic [7:0] c, input logic last);
		result_t    outs [3];
		int         n;
		logic [4:0] dv;
		logic [7:0] v;
		logic       hostish;
		n = 0;
		hostish = (cur_mode == MODE_HOST) || (cur_mode == MODE_ZONE);
		if (!err_seen) begin
			if (cur_dir == DIR_ENCODE) begin
				if (!esc_required(c, cur_mode)) begin
					outs[0] = '{c, 1'b0, 1'b0};
					n = 1;
				end else if (c == CH_SPACE && cur_mode == MODE_QUERY) begin
					outs[0] = '{CH_PLUS, 1'b0, 1'b0};
					n = 1;
				end else begin
					outs[0] = '{CH_PCT, 1'b0, 1'b0};
					outs[1] = '{nibble_char(c[7:4]), 1'b0, 1'b0};
					outs[2] = '{nibble_char(c[3:0]), 1'b0, 1'b0};
					n = 3;
				end
			end else begin
				case (esc_phase)
					ESC_NONE: begin
						if (c == CH_PCT) begin
							esc_phase = ESC_OPEN;
						end else if (c == CH_PLUS) begin
							outs[0] = '{(cur_mode == MODE_QUERY) ? CH_SPACE : CH_PLUS, 1'b0, 1'b0};
							n = 1;
						end else if (hostish && c < 8'h80 && esc_required(c, cur_mode)) begin
							err_seen = 1'b1;
						end else begin
							outs[0] = '{c, 1'b0, 1'b0};
							n = 1;
						end
					end
					ESC_OPEN: begin
						dv = digit_value(c);
						if (!dv[4]) begin
							err_seen = 1'b1;
						end else begin
							hi_nib = dv[3:0];
							esc_phase = ESC_HALF;
						end
					end
					default: begin
						dv = digit_value(c);
						if (!dv[4]) begin
							err_seen = 1'b1;
						end else begin
							v = {hi_nib, dv[3:0]};
							if (cur_mode == MODE_HOST && !hi_nib[3] && v != CH_PCT) begin
								err_seen = 1'b1;
							end else if (cur_mode == MODE_ZONE && v != CH_PCT && v != CH_SPACE
									&& esc_required(v, MODE_HOST)) begin
								err_seen = 1'b1;
							end else begin
								outs[0] = '{v, 1'b0, 1'b0};
								n = 1;
							end
							esc_phase = ESC_NONE;
							hi_nib = 4'd0;
						end
					end
				endcase
			end
			if (err_seen)
				n = 0;
		end
		if (last) begin
			if (cur_dir == DIR_DECODE && esc_phase != ESC_NONE)
				err_seen = 1'b1;
			if (err_seen) begin
				outs[0] = '{8'h00, 1'b1, 1'b1};
				n = 1;
			end else if (n > 0) begin
				outs[n-1].last = 1'b1;
			end else begin
				outs[0] = '{8'h00, 1'b1, 1'b0};
				n = 1;
			end
			esc_phase = ESC_NONE;
			hi_nib = 4'd0;
			err_seen = 1'b0;
		end
		for (int k = 0; k < n; k++)
			expected_chars.insert(expected_chars.size(), outs[k]);
	endtask

	always @(negedge clk) begin : feeder
		in_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
				item = pending_bytes.pop_front();
				in_valid <= 1'b1;
				in_byte <= item.b;
				in_last <= item.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// hold off once for a long stretch so that the block backs up into its input
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AT
				&& pending_bytes.size() >= HOLD_MIN_PENDING) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	always @(posedge clk) begin : observer
		result_t want;
		in_taken <= arst_n && ingress_bus.valid && ingress_bus.ready;
		if (arst_n && ingress_bus.valid && ingress_bus.ready) begin
			percent_codec_step(ingress_bus.in_byte, ingress_bus.in_last);
			items_accepted++;
		end
		if (arst_n && egress_bus.valid && egress_bus.ready) begin
			results_seen <= results_seen + 1;
			if (expected_chars.size() == 0) begin
				$error("unexpected transaction: out_byte %02h out_last %0b out_error %0b",
					egress_bus.out_byte, egress_bus.out_last, egress_bus.out_error);
				fail_count++;
			end else begin
				want = expected_chars.pop_front();
				if (egress_bus.out_byte !== want.ch) begin
					$error("out_byte: expected %02h, actual %02h", want.ch, egress_bus.out_byte);
					fail_count++;
				end
				if (egress_bus.out_last !== want.last) begin
					$error("out_last: expected %0b, actual %0b", want.last, egress_bus.out_last);
					fail_count++;
				end
				if (egress_bus.out_error !== want.err) begin
					$error("out_error: expected %0b, actual %0b", want.err, egress_bus.out_error);
					fail_count++;
				end
			end
		end
	end

	task automatic settle();
		do
			@(negedge clk);
		while (items_accepted != items_queued || expected_chars.size() != 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_DIRECTION)
			cur_dir = val[0];
		else
			cur_mode = mode_t'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_codec(input logic dir, input mode_t m);
		write_reg(REG_DIRECTION, {2'($urandom_range(3)), dir});
		write_reg(REG_ESC_MODE, m);
	endtask

	task automatic send(input logic [7:0] b, input logic last);
		pending_bytes.insert(pending_bytes.size(), in_item_t'{b, last});
		items_queued++;
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			send(s[i], close && (i == s.len() - 1));
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int         rand_base;
		int         done;
		int         nstr;
		int         len;
		int         roll;
		logic       close;
		logic       tail;
		logic [7:0] c;
		logic [7:0] v;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_codec(DIR_ENCODE, MODE_PATH);
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send("?", 1'b0);
		send("a", 1'b1);
		set_codec(DIR_ENCODE, MODE_QUERY);
		send(CH_SPACE, 1'b0);
		send(CH_PLUS, 1'b1);
		write_reg(REG_ESC_MODE, MODE_SPARE);
		send("/", 1'b1);
		set_codec(DIR_DECODE, MODE_QUERY);
		send_text("%eF+%4", 1'b0);
		// switch direction with an escape still open
		write_reg(REG_DIRECTION, cfg_data_t'(DIR_ENCODE));
		send("~", 1'b1);
		set_codec(DIR_DECODE, MODE_HOST);
		send_text("%41", 1'b1);
		write_reg(REG_ESC_MODE, MODE_ZONE);
		send_text("%7b", 1'b1);
		write_reg(REG_ESC_MODE, MODE_FRAGMENT);
		send(8'hC3, 1'b0);
		send_text("%G", 1'b0);
		send("x", 1'b1);
		send(CH_PCT, 1'b1);

		rand_base = items_queued;
		while (items_queued - rand_base < RAND_ITEMS) begin
			if ($urandom_range(1) == 1)
				write_reg(REG_DIRECTION, cfg_data_t'($urandom_range(7)));
			write_reg(REG_ESC_MODE,
				($urandom_range(15) == 0) ? MODE_SPARE : mode_t'($urandom_range(6)));
			done = items_queued - rand_base;
			if (done >= 100 && done < 170) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end else begin
				in_idle_pct = IDLE_PCT;
				out_idle_pct = IDLE_PCT;
			end
			nstr = $urandom_range(1, 4);
			for (int s = 0; s < nstr; s++) begin
				close = (s != nstr - 1) || ($urandom_range(4) != 0);
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					tail = close && (k == len - 1);
					roll = $urandom_range(99);
					if (roll < 12) begin
						case ($urandom_range(3))
							0: c = 8'($urandom_range(255));
							1: c = CH_PCT;
							2: c = CH_PLUS;
							default: c = ($urandom_range(1) == 1) ? "g"
								: nibble_char(4'($urandom_range(15)));
						endcase
						send(c, tail);
					end else if (cur_dir == DIR_DECODE && roll < 45) begin
						v = 8'($urandom_range(255));
						if (cur_mode == MODE_HOST && $urandom_range(4) != 0) begin
							v = ($urandom_range(3) == 0) ? CH_PCT : {1'b1, v[6:0]};
						end else if (cur_mode == MODE_ZONE && $urandom_range(4) != 0) begin
							while (v != CH_PCT && v != CH_SPACE && esc_required(v, MODE_HOST))
								v = 8'($urandom_range(255));
						end
						send(CH_PCT, 1'b0);
						send(rand_hex_char(v[7:4]), 1'b0);
						send(rand_hex_char(v[3:0]), tail);
					end else begin
						if (cur_dir == DIR_ENCODE) begin
							c = ($urandom_range(1) == 1) ? 8'($urandom_range(255))
								: 8'($urandom_range(32, 126));
						end else begin
							do
								c = ($urandom_range(3) == 0) ? 8'($urandom_range(128, 255))
									: 8'($urandom_range(32, 126));
							while (c == CH_PCT || ((cur_mode == MODE_HOST || cur_mode == MODE_ZONE)
								&& c < 8'h80 && esc_required(c, cur_mode)));
						end
						send(c, tail);
					end
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
